// ===== sv/coverage_color_blend_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the coverage color blend
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef COVERAGE_COLOR_BLEND_ASSERT_SVH
`define COVERAGE_COLOR_BLEND_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define CCB_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (pre) |-> (post)) else $error(msg);

// next-cycle implication, off while reset is asserted
`define CCB_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (pre) |=> (post)) else $error(msg);

// next-cycle implication that also holds through reset
`define CCB_ASSERT_RST(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) \
        (pre) |=> (post)) else $error(msg);

`endif

// ===== sv/ccb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccb_pkg
// Types, register codes and the divide-by-255 helper for the color blend.
// ----------------------------------------------------------------------------
package ccb_pkg;

    localparam int unsigned CfgIdxW = 3;
    localparam logic [7:0]  FullScale = 8'd255;

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_COLOR_PRESENT = 3'd0,
        CFG_FG_BLUE       = 3'd1,
        CFG_FG_GREEN      = 3'd2,
        CFG_FG_RED        = 3'd3,
        CFG_FG_ALPHA      = 3'd4
    } t_cfg_idx;

    // input word
    typedef struct packed {
        logic [7:0] coverage;
        logic [7:0] dst_blue;
        logic [7:0] dst_green;
        logic [7:0] dst_red;
        logic [7:0] dst_alpha;
    } t_in_word;

    // output word
    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic [7:0] out_alpha;
    } t_out_word;

    // layer color as held in the configuration registers
    typedef struct packed {
        logic       present;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
    } t_layer_cfg;

    // BGRA pixel
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
    } t_pixel;

    // word handed from the alpha stages to the mix stages
    typedef struct packed {
        t_pixel     dst;
        logic [7:0] src_blue;
        logic [7:0] src_green;
        logic [7:0] src_red;
        logic [7:0] fa;
        logic [7:0] inv;
    } t_alpha_word;

    // floor(p / 255) for any 8x8 product p (up to 255*255):
    // (p + (p >> 8) + 1) >> 8
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] s;
        s = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
        return s[15:8];
    endfunction

endpackage

// ===== sv/ccb_alpha.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccb_alpha
// Stages 1 and 2: pick the layer color, form alpha*coverage, then reduce it
// to the effective alpha and its complement.
// ----------------------------------------------------------------------------
module ccb_alpha (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ccb_pkg::t_layer_cfg i_layer,
    input  logic                i_valid,
    input  ccb_pkg::t_in_word   i_data,
    output logic                o_ready,
    output logic                o_valid,
    output ccb_pkg::t_alpha_word o_data,
    input  logic                i_next_ready
);

    logic                 r_s1_valid;
    logic [15:0]          r_s1_prod;
    ccb_pkg::t_pixel      r_s1_dst;
    logic [7:0]           r_s1_src_b;
    logic [7:0]           r_s1_src_g;
    logic [7:0]           r_s1_src_r;
    logic                 r_s2_valid;
    ccb_pkg::t_alpha_word r_s2_data;

    logic                 s1_en;
    logic                 s2_en;
    logic [7:0]           src_b;
    logic [7:0]           src_g;
    logic [7:0]           src_r;
    logic [7:0]           src_a;
    logic [7:0]           n_fa;

    // stage enables: a stage loads when empty or when its word moves on
    assign s2_en   = !r_s2_valid || i_next_ready;
    assign s1_en   = !r_s1_valid || s2_en;
    assign o_ready = s1_en;

    // layer color, opaque black without a palette color
    always_comb begin
        if (i_layer.present) begin
            src_b = i_layer.blue;
            src_g = i_layer.green;
            src_r = i_layer.red;
            src_a = i_layer.alpha;
        end else begin
            src_b = 8'd0;
            src_g = 8'd0;
            src_r = 8'd0;
            src_a = ccb_pkg::FullScale;
        end
    end

    // stage 1 valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_en) begin
            r_s1_valid <= i_valid;
        end
    end

    // stage 1 payload: alpha times coverage
    always_ff @(posedge i_clk) begin
        if (s1_en && i_valid) begin
            r_s1_prod  <= src_a * i_data.coverage;
            r_s1_dst   <= '{blue:  i_data.dst_blue,  green: i_data.dst_green,
                            red:   i_data.dst_red,   alpha: i_data.dst_alpha};
            r_s1_src_b <= src_b;
            r_s1_src_g <= src_g;
            r_s1_src_r <= src_r;
        end
    end

    assign n_fa = ccb_pkg::div255(r_s1_prod);

    // stage 2 valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    // stage 2 payload: effective alpha and 255 - alpha
    always_ff @(posedge i_clk) begin
        if (s2_en && r_s1_valid) begin
            r_s2_data.dst       <= r_s1_dst;
            r_s2_data.src_blue  <= r_s1_src_b;
            r_s2_data.src_green <= r_s1_src_g;
            r_s2_data.src_red   <= r_s1_src_r;
            r_s2_data.fa        <= n_fa;
            r_s2_data.inv       <= ccb_pkg::FullScale - n_fa;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_data  = r_s2_data;

endmodule

// ===== sv/ccb_mix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccb_mix
// Stages 3 and 4: scale destination and source per channel, then reduce and
// add into the output register.
// ----------------------------------------------------------------------------
module ccb_mix (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  ccb_pkg::t_alpha_word i_data,
    output logic                 o_ready,
    output logic                 o_valid,
    output ccb_pkg::t_out_word   o_data,
    input  logic                 i_stall
);

    logic               r_s3_valid;
    logic [15:0]        r_s3_db;
    logic [15:0]        r_s3_dg;
    logic [15:0]        r_s3_dr;
    logic [15:0]        r_s3_da;
    logic [15:0]        r_s3_sb;
    logic [15:0]        r_s3_sg;
    logic [15:0]        r_s3_sr;
    logic [7:0]         r_s3_fa;
    logic               r_s4_valid;
    ccb_pkg::t_out_word r_s4_data;

    logic               s3_en;
    logic               s4_en;

    assign s4_en   = !r_s4_valid || !i_stall;
    assign s3_en   = !r_s3_valid || s4_en;
    assign o_ready = s3_en;

    // stage 3 valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (s3_en) begin
            r_s3_valid <= i_valid;
        end
    end

    // stage 3 payload: seven 8x8 products
    always_ff @(posedge i_clk) begin
        if (s3_en && i_valid) begin
            r_s3_db <= i_data.dst.blue  * i_data.inv;
            r_s3_dg <= i_data.dst.green * i_data.inv;
            r_s3_dr <= i_data.dst.red   * i_data.inv;
            r_s3_da <= i_data.dst.alpha * i_data.inv;
            r_s3_sb <= i_data.src_blue  * i_data.fa;
            r_s3_sg <= i_data.src_green * i_data.fa;
            r_s3_sr <= i_data.src_red   * i_data.fa;
            r_s3_fa <= i_data.fa;
        end
    end

    // stage 4 valid (output register)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (s4_en) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    // stage 4 payload: sums never pass 255, kept to 8 bits
    always_ff @(posedge i_clk) begin
        if (s4_en && r_s3_valid) begin
            r_s4_data.out_blue  <= ccb_pkg::div255(r_s3_db) + ccb_pkg::div255(r_s3_sb);
            r_s4_data.out_green <= ccb_pkg::div255(r_s3_dg) + ccb_pkg::div255(r_s3_sg);
            r_s4_data.out_red   <= ccb_pkg::div255(r_s3_dr) + ccb_pkg::div255(r_s3_sr);
            r_s4_data.out_alpha <= ccb_pkg::div255(r_s3_da) + r_s3_fa;
        end
    end

    assign o_valid = r_s4_valid;
    assign o_data  = r_s4_data;

endmodule

// ===== sv/coverage_color_blend.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coverage_color_blend
// Source-over blend of a coverage-modulated layer color onto BGRA pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one word per
//   pixel: glyph coverage and the current destination BGRA bytes. Output
//   channel (o_out_valid / i_out_stall / o_out_data) returns the blended
//   pixel, one word per input word, in order.
//   The layer color sits in five registers written through i_cfg_we,
//   i_cfg_idx and i_cfg_wdata; write them only while no pixel is in flight.
//   Indexes above the last register are ignored.
//   Each word passes four register stages (alpha product, alpha reduce,
//   channel products, channel reduce and add) on its way to o_out_data.
//   Throughput: one pixel per cycle while the receiver does not stall.
//   Reset (synchronous, active low) empties the pipeline and loads opaque
//   black with no palette color. When the receiver stalls, the output word
//   holds and the stages behind it keep filling until full; only then does
//   o_in_stall rise. No word is dropped or repeated.
// ----------------------------------------------------------------------------
module coverage_color_blend (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ccb_pkg::t_in_word   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ccb_pkg::t_out_word  o_out_data,
    input  logic                i_cfg_we,
    input  logic [ccb_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [7:0]          i_cfg_wdata
);

    ccb_pkg::t_layer_cfg  r_layer;
    logic                 alpha_ready;
    logic                 mid_valid;
    ccb_pkg::t_alpha_word mid_data;
    logic                 mix_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer.present <= 1'b0;
            r_layer.blue    <= 8'd0;
            r_layer.green   <= 8'd0;
            r_layer.red     <= 8'd0;
            r_layer.alpha   <= ccb_pkg::FullScale;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ccb_pkg::CFG_COLOR_PRESENT: r_layer.present <= i_cfg_wdata[0];
                ccb_pkg::CFG_FG_BLUE:       r_layer.blue    <= i_cfg_wdata;
                ccb_pkg::CFG_FG_GREEN:      r_layer.green   <= i_cfg_wdata;
                ccb_pkg::CFG_FG_RED:        r_layer.red     <= i_cfg_wdata;
                ccb_pkg::CFG_FG_ALPHA:      r_layer.alpha   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // stages 1-2
    ccb_alpha u_alpha (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_layer      (r_layer),
        .i_valid      (i_in_valid),
        .i_data       (i_in_data),
        .o_ready      (alpha_ready),
        .o_valid      (mid_valid),
        .o_data       (mid_data),
        .i_next_ready (mix_ready)
    );

    // stages 3-4
    ccb_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mid_valid),
        .i_data  (mid_data),
        .o_ready (mix_ready),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

    assign o_in_stall = !alpha_ready;

endmodule

// ===== sv/ccb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccb_checker
// Port-level checks on the color blend, bound to the top level.
// ----------------------------------------------------------------------------
`include "coverage_color_blend_assert.svh"

module ccb_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input ccb_pkg::t_out_word  o_out_data
);

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    // a stalled output word holds
    `CCB_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "output word changed under stall")

    // reset leaves no word on the output
    `CCB_ASSERT_RST(a_rst_empty, !i_rst_n, !o_out_valid, "output valid right after reset")

    // an empty output register means the whole pipeline can take a word
    `CCB_ASSERT_NOW(a_empty_ready, !o_out_valid, !o_in_stall, "input stalled with empty output")

    // with the receiver free, a taken word passes the pipeline stages and reaches the output
    `CCB_ASSERT_NEXT(a_latency, in_acc ##1 !i_out_stall ##1 !i_out_stall ##1 !i_out_stall, o_out_valid, "word missing after pipeline latency")

endmodule

bind coverage_color_blend ccb_checker u_ccb_checker (.*);

// ===== sim/blend_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blend_checker
// Watches the pixel channels and the register port of the color blend. Keeps
// its own copy of the layer color, works out each blended pixel when the
// input word is taken, and compares it against the next output word.
// ----------------------------------------------------------------------------
module blend_checker
    import ccb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_word             i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_word            i_out_data,
    input  logic                 i_cfg_we,
    input  logic [CfgIdxW-1:0]   i_cfg_idx,
    input  logic [7:0]           i_cfg_wdata,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_checked
);

    localparam int MaxReports = 40;

    t_layer_cfg layer;
    t_out_word  expected_pixels[$];
    t_out_word  want;
    int         err_count   = 0;
    int         check_count = 0;
    int         pending     = 0;

    assign o_errors  = err_count;
    assign o_pending = pending;
    assign o_checked = check_count;

    // floor(v * a / 255), the truncating scale used on every channel
    function automatic logic [7:0] scale_255(input logic [7:0] v, input logic [7:0] a);
        logic [15:0] p;
        p = {8'd0, v} * {8'd0, a};
        return 8'(p / 16'd255);
    endfunction

    // source-over blend of the layer color, weighted by coverage
    function automatic t_out_word blend_pixel(input t_layer_cfg lc, input t_in_word px);
        logic [7:0] src_b;
        logic [7:0] src_g;
        logic [7:0] src_r;
        logic [7:0] src_a;
        logic [7:0] fa;
        logic [7:0] inv;
        t_out_word  res;
        // no palette color: opaque black, fg bytes ignored
        if (lc.present) begin
            src_b = lc.blue;
            src_g = lc.green;
            src_r = lc.red;
            src_a = lc.alpha;
        end else begin
            src_b = 8'd0;
            src_g = 8'd0;
            src_r = 8'd0;
            src_a = FullScale;
        end
        fa  = scale_255(src_a, px.coverage);
        inv = FullScale - fa;
        // 8-bit sums wrap like the masked outputs (never reached in practice)
        res.out_blue  = scale_255(px.dst_blue, inv) + scale_255(src_b, fa);
        res.out_green = scale_255(px.dst_green, inv) + scale_255(src_g, fa);
        res.out_red   = scale_255(px.dst_red, inv) + scale_255(src_r, fa);
        res.out_alpha = scale_255(px.dst_alpha, inv) + fa;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < MaxReports) begin
            $display("[%0t] MISMATCH %s", $time, msg);
        end
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
        if (got_v !== exp_v) begin
            report_mismatch($sformatf("pixel %0d %s: expected %0d, got %0d",
                                      check_count, name, exp_v, got_v));
        end
    endtask

    // track registers, predict on input words, compare on output words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            layer = '{present: 1'b0, blue: 8'd0, green: 8'd0, red: 8'd0,
                      alpha: FullScale};
            expected_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_COLOR_PRESENT: layer.present = i_cfg_wdata[0];
                    CFG_FG_BLUE:       layer.blue    = i_cfg_wdata;
                    CFG_FG_GREEN:      layer.green   = i_cfg_wdata;
                    CFG_FG_RED:        layer.red     = i_cfg_wdata;
                    CFG_FG_ALPHA:      layer.alpha   = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch($sformatf("output word %h with no pixel pending",
                                              i_out_data));
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("blue",  want.out_blue,  i_out_data.out_blue);
                    check_field("green", want.out_green, i_out_data.out_green);
                    check_field("red",   want.out_red,   i_out_data.out_red);
                    check_field("alpha", want.out_alpha, i_out_data.out_alpha);
                end
                check_count++;
            end
            if (i_in_valid && !i_in_stall) begin
                expected_pixels.push_back(blend_pixel(layer, i_in_data));
            end
        end
        pending = expected_pixels.size();
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the coverage color blend: directed corner pixels under a few
// layer colors, then random pixels over several random layer settings with
// random pacing on both channels, an output hold-off and a mid-stream drain.
// ----------------------------------------------------------------------------
module tb_top;
    import ccb_pkg::*;

    localparam int PipeLatency    = 4;
    localparam int ResetCycles    = 12;
    localparam int HoldOffCycles  = 150;
    localparam int WatchdogLimit  = 2000;
    localparam int RandomPhases   = 8;
    localparam int PixelsPerPhase = 110;

    typedef enum int {PACE_BACK_TO_BACK, PACE_RANDOM, PACE_BURSTY} t_pace;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_in_word             in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_word            out_data;
    logic                 cfg_we    = 1'b0;
    logic [CfgIdxW-1:0]   cfg_idx   = '0;
    logic [7:0]           cfg_wdata = '0;

    int    errors;
    int    pending;
    int    checked;
    int    quiet_cycles    = 0;
    int    pixels_sent     = 0;
    int    layer_settings  = 0;
    int    hold_off_cycles = 0;
    t_pace send_pace       = PACE_RANDOM;
    t_pace recv_pace       = PACE_RANDOM;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    coverage_color_blend dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    blend_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    function automatic int draw_gap(input t_pace pace);
        case (pace)
            PACE_BACK_TO_BACK: return 0;
            PACE_RANDOM:       return $urandom_range(0, 12);
            default:           return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 0;
        endcase
    endfunction

    function automatic t_in_word pix(input logic [7:0] cov, input logic [7:0] b,
                                     input logic [7:0] g, input logic [7:0] r,
                                     input logic [7:0] a);
        t_in_word w;
        w = {cov, b, g, r, a};
        return w;
    endfunction

    // coverage leans toward its edges; destination bytes fully random
    function automatic t_in_word random_pixel();
        logic [7:0] cov;
        case ($urandom_range(0, 7))
            0:       cov = 8'h00;
            1:       cov = 8'hff;
            2:       cov = 8'h01;
            3:       cov = 8'hfe;
            default: cov = 8'($urandom);
        endcase
        return pix(cov, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    function automatic logic [7:0] random_channel();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    // offer one word after a random gap; returns at the edge that takes it
    task automatic send_pixel(input t_in_word w);
        int gap;
        gap = draw_gap(send_pace);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (in_stall);
        pixels_sent++;
    endtask

    // stop offering and let every pending pixel come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (PipeLatency) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic program_layer(input logic [7:0] present, input logic [7:0] b,
                                 input logic [7:0] g, input logic [7:0] r,
                                 input logic [7:0] a);
        write_reg(CFG_COLOR_PRESENT, present);
        write_reg(CFG_FG_BLUE, b);
        write_reg(CFG_FG_GREEN, g);
        write_reg(CFG_FG_RED, r);
        write_reg(CFG_FG_ALPHA, a);
        layer_settings++;
    endtask

    // receiver: random stalls per word, plus one long hold-off on request
    initial begin : receiver
        int gap;
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_off_cycles > 0) begin
                gap = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                gap = draw_gap(recv_pace);
            end
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // watchdog: cycles with no word moving on either channel
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WatchdogLimit) begin
            $display("Timeout: no word moved for %0d cycles", WatchdogLimit);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stimulus
        int phase;
        int n;
        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset layer: no palette color, opaque black
        layer_settings++;
        send_pixel(pix(8'h00, 8'hff, 8'hff, 8'hff, 8'hff));
        send_pixel(pix(8'hff, 8'h00, 8'h00, 8'h00, 8'h00));
        send_pixel(pix(8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
        send_pixel(pix(8'h80, 8'h12, 8'h34, 8'h56, 8'h78));
        send_pixel(pix(8'h01, 8'hff, 8'hff, 8'hff, 8'hff));

        // opaque white
        wait_drained();
        program_layer(8'h01, 8'hff, 8'hff, 8'hff, 8'hff);
        send_pixel(pix(8'hff, 8'h00, 8'h00, 8'h00, 8'h00));
        send_pixel(pix(8'hfe, 8'hff, 8'hff, 8'hff, 8'hff));
        send_pixel(pix(8'h00, 8'haa, 8'h55, 8'haa, 8'h55));

        // fully transparent color
        wait_drained();
        program_layer(8'h01, 8'h55, 8'haa, 8'h0f, 8'h00);
        send_pixel(pix(8'hff, 8'h55, 8'haa, 8'h0f, 8'hf0));
        send_pixel(pix(8'h7f, 8'h01, 8'h02, 8'h03, 8'h04));

        // present flag written with bit 0 clear: colors must be ignored
        wait_drained();
        program_layer(8'hfe, 8'h55, 8'haa, 8'h0f, 8'h80);
        send_pixel(pix(8'hff, 8'h80, 8'h80, 8'h80, 8'h80));
        send_pixel(pix(8'h40, 8'hc3, 8'h3c, 8'hc3, 8'h3c));

        // writes past the last register must not touch the color
        wait_drained();
        for (int idx = int'(CFG_FG_ALPHA) + 1; idx < (1 << CfgIdxW); idx++) begin
            write_reg(CfgIdxW'(idx), 8'h00);
        end
        write_reg(CFG_COLOR_PRESENT, 8'h01);
        layer_settings++;
        send_pixel(pix(8'hff, 8'h00, 8'h00, 8'h00, 8'h00));
        send_pixel(pix(8'hc0, 8'hff, 8'h00, 8'hff, 8'h00));

        // random pixels over random layer colors
        for (phase = 0; phase < RandomPhases; phase++) begin
            wait_drained();
            case (phase)
                0: program_layer({7'($urandom), 1'b1}, random_channel(), random_channel(),
                                 random_channel(), FullScale);
                1: program_layer({7'($urandom), 1'b1}, random_channel(), random_channel(),
                                 random_channel(), 8'h00);
                2: program_layer({7'($urandom), 1'b0}, 8'($urandom), 8'($urandom),
                                 8'($urandom), 8'($urandom));
                default: program_layer(8'($urandom), random_channel(), random_channel(),
                                       random_channel(), random_channel());
            endcase
            if (phase == 0) begin
                send_pace = PACE_BACK_TO_BACK;
                recv_pace = PACE_BACK_TO_BACK;
            end else begin
                send_pace = t_pace'($urandom_range(0, 2));
                recv_pace = t_pace'($urandom_range(0, 2));
            end
            // long output hold-off while words keep coming: pipeline fills
            if (phase == 3) begin
                send_pace = PACE_BACK_TO_BACK;
                hold_off_cycles = HoldOffCycles;
            end
            for (n = 0; n < PixelsPerPhase; n++) begin
                if (phase == 5 && n == PixelsPerPhase / 2) begin
                    wait_drained();
                end
                send_pixel(random_pixel());
            end
        end

        wait_drained();
        $display("Summary: %0d pixels blended under %0d layer color settings, %0d checked.",
                 pixels_sent, layer_settings, checked);
        $display("Covered back-to-back and random pacing, a %0d-cycle output hold-off %s",
                 HoldOffCycles, "and a mid-stream drain.");
        if (errors == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
